@@ hdl/nhs_pkg.sv @@
// Shared constants, codes and types for the NAL header scanner.
// No dependencies; the design modules and the testbench import this package.
`timescale 1ns / 1ps

package nhs_pkg;

   // Default scan window in bytes and depth of the front-to-back queue.
   localparam int NHS_WINDOW      = 256;
   localparam int NHS_QUEUE_DEPTH = 4;

   // Bytes of history: three start-code bytes plus two header bytes.
   localparam int HIST_DEPTH       = 5;
   // Offset from a start code to its NAL header byte.
   localparam int HDR_OFFSET       = 3;
   // Scanning stops once this many checkpoints have been counted.
   localparam int CHECKPOINT_LIMIT = 4;

   // NAL unit type codes.
   localparam logic [4:0] NAL_IDR        = 5'd5;
   localparam logic [4:0] NAL_DATA_LIMIT = 5'd6;
   localparam logic [4:0] NAL_SPS        = 5'd7;
   localparam logic [4:0] NAL_PPS        = 5'd8;
   localparam logic [4:0] NAL_FU_A       = 5'd28;
   localparam logic [4:0] NAL_FU_B       = 5'd29;

   // Start-code bytes.
   localparam logic [7:0] START_ZERO = 8'h00;
   localparam logic [7:0] START_ONE  = 8'h01;

   // Classification of one examined start code.
   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_DATA  = 3'd1;
   localparam logic [2:0] KIND_KEY   = 3'd2;
   localparam logic [2:0] KIND_SPS   = 3'd3;
   localparam logic [2:0] KIND_PPS   = 3'd4;

   // Control part of an event passed from the front to the back.
   typedef struct packed {
      logic       exam;
      logic       last;
      logic [2:0] kind;
   } nhs_event_type;

endpackage

@@ hdl/nhs_intf.sv @@
// Valid/ready channel interfaces for the byte input and the summary output.
// No dependencies.
`timescale 1ns / 1ps

interface nhs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface nhs_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_key;
   logic       has_data;
   logic       has_sps;
   logic [7:0] sps_offset;
   logic [8:0] sps_length;
   logic       has_pps;
   logic [7:0] pps_offset;
   logic [8:0] pps_length;

   modport source (output valid, output is_key, output has_data, output has_sps,
                   output sps_offset, output sps_length, output has_pps,
                   output pps_offset, output pps_length, input ready);
   modport sink   (input valid, input is_key, input has_data, input has_sps,
                   input sps_offset, input sps_length, input has_pps,
                   input pps_offset, input pps_length, output ready);
endinterface

@@ hdl/h264_nal_header_scanner_top.sv @@
// Top level of the H.264 NAL header scanner: front end, event queue, back end.
// Uses nhs_pkg, nhs_intf, nhs_front, nhs_queue and nhs_back.
`timescale 1ns / 1ps

// Usage:
// Bytes of one Annex B frame enter on req_chan (byte_value, last_byte) with a
// valid/ready handshake; last_byte marks the final byte of the frame. Only the
// first WINDOW bytes are scanned for 00 00 01 start codes. On the transfer of
// the last byte one summary (key/data flags, SPS and PPS offsets and lengths)
// leaves on rsp_chan; no other byte produces a result.
// Throughput is one byte per cycle while the event queue has room, also
// across frame boundaries. rsp_chan.valid rises once the last byte's event,
// written into the queue at the transfer edge, reaches the back end and the
// back end loads its result register; older queued events go first.
// The back end handles one queued event per cycle unless a frame-end event
// waits for the result register; only bytes that carry an examined start
// code or end a frame enter the queue.
// When the receiver stalls, the summary waits in the result register; the
// back end holds at the next frame end and the front end keeps taking bytes
// until the queue (QUEUE_DEPTH events) is full, then drops req_chan.ready.
// Synchronous reset clears the history, counters, queue and pending result;
// no clearing pass is needed, and the block takes bytes right after reset.

module h264_nal_header_scanner_top
   import nhs_pkg::*;
#(
   parameter int WINDOW      = NHS_WINDOW,
   parameter int QUEUE_DEPTH = NHS_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   nhs_req_if.sink     req_chan,
   nhs_rsp_if.source   rsp_chan
);

   localparam int IW = $clog2(WINDOW + 1);
   localparam int EW = $bits(nhs_event_type) + IW;

   logic             q_ready;
   logic             ev_valid;
   nhs_event_type    ev_ctrl;
   logic [IW-1:0]    ev_index;
   logic             q_valid;
   logic [EW-1:0]    q_data;
   nhs_event_type    q_ctrl;
   logic [IW-1:0]    q_index;
   logic             q_pop;

   // Front end: history and classification.
   nhs_front #(
      .WINDOW (WINDOW),
      .IW     (IW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_ready  (q_ready),
      .ev_valid (ev_valid),
      .ev_ctrl  (ev_ctrl),
      .ev_index (ev_index)
   );

   // Event queue between the two halves.
   nhs_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ev_valid),
      .push_data  ({ev_ctrl, ev_index}),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   assign q_ctrl  = q_data[EW-1:IW];
   assign q_index = q_data[IW-1:0];

   // Back end: frame state and result register.
   nhs_back #(
      .WINDOW (WINDOW),
      .IW     (IW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (q_valid),
      .ev_ctrl  (q_ctrl),
      .ev_index (q_index),
      .ev_pop   (q_pop),
      .rsp_chan (rsp_chan)
   );

   // The front end never hands an event to a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      ev_valid |-> q_ready)
      else $error("event pushed into a full queue");

   // Every key frame also counts as holding data.
   a_key_has_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_key) |-> rsp_chan.has_data)
      else $error("key frame reported without data");

   // Without an SPS its offset and length read zero.
   a_sps_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_sps) |->
         (rsp_chan.sps_offset == 8'd0 && rsp_chan.sps_length == 9'd0))
      else $error("SPS record set without an SPS");

   // Without a PPS its offset and length read zero.
   a_pps_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_pps) |->
         (rsp_chan.pps_offset == 8'd0 && rsp_chan.pps_length == 9'd0))
      else $error("PPS record set without a PPS");

endmodule

@@ hdl/nhs_front.sv @@
// Front end: accepts frame bytes, keeps the five-byte history and the byte
// index, detects start codes and classifies NAL headers. Uses nhs_pkg, nhs_intf.
`timescale 1ns / 1ps

module nhs_front
   import nhs_pkg::*;
#(
   parameter int WINDOW = NHS_WINDOW,
   parameter int IW     = $clog2(WINDOW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   nhs_req_if.sink          req_chan,
   input  logic             q_ready,
   output logic             ev_valid,
   output nhs_event_type    ev_ctrl,
   output logic [IW-1:0]    ev_index
);

   logic [7:0]    hist_ff [HIST_DEPTH];
   logic [7:0]    hist_in [HIST_DEPTH];
   logic [IW-1:0] index_ff;
   logic [IW-1:0] index_in;
   logic          accept;
   logic          start_code;
   logic          in_range;
   logic [4:0]    ftype;
   logic [4:0]    ftype_next;
   logic          fu_idr_start;
   logic [2:0]    kind;

   assign req_chan.ready = q_ready;
   assign accept         = req_chan.valid && q_ready;

   // Start code in the oldest three bytes, header bytes after it.
   assign start_code = (hist_ff[0] == START_ZERO) && (hist_ff[1] == START_ZERO) &&
                       (hist_ff[2] == START_ONE);
   assign in_range   = (index_ff >= IW'(HIST_DEPTH)) && (index_ff < IW'(WINDOW));
   assign ftype      = hist_ff[3][4:0];
   assign ftype_next = hist_ff[4][4:0];
   assign fu_idr_start = ((ftype == NAL_FU_A) || (ftype == NAL_FU_B)) &&
                         (ftype_next == NAL_IDR) && hist_ff[4][7];

   // Classify the NAL header behind the start code.
   always_comb begin
      if ((ftype == NAL_IDR) || fu_idr_start) begin
         kind = KIND_KEY;
      end else if (ftype == NAL_SPS) begin
         kind = KIND_SPS;
      end else if (ftype == NAL_PPS) begin
         kind = KIND_PPS;
      end else if (ftype < NAL_DATA_LIMIT) begin
         kind = KIND_DATA;
      end else begin
         kind = KIND_OTHER;
      end
   end

   // An event goes to the back end for every examined start code and frame end.
   assign ev_ctrl.exam = start_code && in_range;
   assign ev_ctrl.last = req_chan.last_byte;
   assign ev_ctrl.kind = kind;
   assign ev_index     = index_ff;
   assign ev_valid     = accept && (ev_ctrl.exam || req_chan.last_byte);

   // History shift and saturating byte index; both clear at frame end.
   always_comb begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      index_in = index_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
               hist_in[i] = '0;
            end
            index_in = '0;
         end else begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
               hist_in[i] = hist_ff[i + 1];
            end
            hist_in[HIST_DEPTH - 1] = req_chan.byte_value;
            if (index_ff < IW'(WINDOW)) begin
               index_in = index_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         index_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         index_ff <= index_in;
      end
   end

endmodule

@@ hdl/nhs_queue.sv @@
// Small first-in first-out queue that decouples the front and back ends.
// Uses nhs_pkg for its default depth; no other dependencies.
`timescale 1ns / 1ps

module nhs_queue
   import nhs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = NHS_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/nhs_back.sv @@
// Back end: applies examined start codes to the per-frame flags and records,
// counts checkpoints and holds the summary result. Uses nhs_pkg, nhs_intf.
`timescale 1ns / 1ps

module nhs_back
   import nhs_pkg::*;
#(
   parameter int WINDOW = NHS_WINDOW,
   parameter int IW     = $clog2(WINDOW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             ev_valid,
   input  nhs_event_type    ev_ctrl,
   input  logic [IW-1:0]    ev_index,
   output logic             ev_pop,
   nhs_rsp_if.source        rsp_chan
);

   localparam logic [1:0] OPEN_NONE = 2'd0;
   localparam logic [1:0] OPEN_SPS  = 2'd1;
   localparam logic [1:0] OPEN_PPS  = 2'd2;

   // Frame state.
   logic          stopped_ff, stopped_in;
   logic [2:0]    count_ff, count_in;
   logic [1:0]    open_ff, open_in;
   logic          key_ff, key_in;
   logic          data_ff, data_in;
   logic          sps_has_ff, sps_has_in;
   logic [IW-1:0] sps_off_ff, sps_off_in;
   logic [8:0]    sps_len_ff, sps_len_in;
   logic          pps_has_ff, pps_has_in;
   logic [IW-1:0] pps_off_ff, pps_off_in;
   logic [8:0]    pps_len_ff, pps_len_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_key_ff, rsp_data_ff, rsp_sps_ff, rsp_pps_ff;
   logic [7:0]    rsp_sps_off_ff, rsp_pps_off_ff;
   logic [8:0]    rsp_sps_len_ff, rsp_pps_len_ff;
   logic [8:0]    sps_len_final, pps_len_final;

   logic          out_free;
   logic          do_exam;
   logic          load_rsp;
   logic [IW-1:0] pos;
   logic [IW-1:0] span;

   // Length from an offset to an end point, zero if the end lies before it.
   function automatic logic [8:0] len_of(input logic [IW-1:0] end_pos,
                                         input logic [IW-1:0] start_pos);
      logic [IW-1:0] diff;
      diff = end_pos - start_pos;
      return (end_pos >= start_pos) ? 9'(diff) : 9'd0;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign ev_pop   = ev_valid && (!ev_ctrl.last || out_free);
   assign do_exam  = ev_pop && ev_ctrl.exam && !stopped_ff;
   assign load_rsp = ev_pop && ev_ctrl.last;

   // Position of the start code, and the scanned extent of the frame.
   assign pos  = ev_index - IW'(HIST_DEPTH);
   assign span = (ev_index < IW'(WINDOW)) ? ev_index + IW'(1) : IW'(WINDOW);

   // Apply one examined start code.
   always_comb begin
      stopped_in = stopped_ff;
      count_in   = count_ff;
      open_in    = open_ff;
      key_in     = key_ff;
      data_in    = data_ff;
      sps_has_in = sps_has_ff;
      sps_off_in = sps_off_ff;
      sps_len_in = sps_len_ff;
      pps_has_in = pps_has_ff;
      pps_off_in = pps_off_ff;
      pps_len_in = pps_len_ff;
      if (do_exam) begin
         // A new start code closes the open parameter set record.
         if (open_ff == OPEN_SPS) begin
            sps_len_in = len_of(pos, sps_off_ff);
         end else if (open_ff == OPEN_PPS) begin
            pps_len_in = len_of(pos, pps_off_ff);
         end
         if (open_ff != OPEN_NONE) begin
            open_in  = OPEN_NONE;
            count_in = count_in + 3'd1;
         end
         case (ev_ctrl.kind)
            KIND_KEY: begin
               key_in   = 1'b1;
               count_in = count_in + 3'd1;
               if (!data_ff) begin
                  data_in  = 1'b1;
                  count_in = count_in + 3'd1;
               end
            end
            KIND_SPS: begin
               sps_has_in = 1'b1;
               sps_off_in = pos + IW'(HDR_OFFSET);
               open_in    = OPEN_SPS;
            end
            KIND_PPS: begin
               pps_has_in = 1'b1;
               pps_off_in = pos + IW'(HDR_OFFSET);
               open_in    = OPEN_PPS;
            end
            KIND_DATA: begin
               if (!data_ff) begin
                  data_in  = 1'b1;
                  count_in = count_in + 3'd1;
               end
            end
            default: begin
            end
         endcase
         if (count_in >= 3'(CHECKPOINT_LIMIT)) begin
            stopped_in = 1'b1;
         end
      end
   end

   // A record still open at frame end runs to the scanned extent.
   always_comb begin
      sps_len_final = sps_len_in;
      pps_len_final = pps_len_in;
      if (open_in == OPEN_SPS) begin
         sps_len_final = len_of(span, sps_off_in);
      end else if (open_in == OPEN_PPS) begin
         pps_len_final = len_of(span, pps_off_in);
      end
   end

   // Result valid: set on a summary, cleared when the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state; everything clears after the summary of a frame.
   always_ff @(posedge clock) begin
      if (reset || load_rsp) begin
         stopped_ff <= 1'b0;
         count_ff   <= '0;
         open_ff    <= OPEN_NONE;
         key_ff     <= 1'b0;
         data_ff    <= 1'b0;
         sps_has_ff <= 1'b0;
         sps_off_ff <= '0;
         sps_len_ff <= '0;
         pps_has_ff <= 1'b0;
         pps_off_ff <= '0;
         pps_len_ff <= '0;
      end else begin
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
         open_ff    <= open_in;
         key_ff     <= key_in;
         data_ff    <= data_in;
         sps_has_ff <= sps_has_in;
         sps_off_ff <= sps_off_in;
         sps_len_ff <= sps_len_in;
         pps_has_ff <= pps_has_in;
         pps_off_ff <= pps_off_in;
         pps_len_ff <= pps_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded when the frame-end event leaves the queue.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_key_ff     <= key_in;
         rsp_data_ff    <= data_in;
         rsp_sps_ff     <= sps_has_in;
         rsp_sps_off_ff <= 8'(sps_off_in);
         rsp_sps_len_ff <= sps_len_final;
         rsp_pps_ff     <= pps_has_in;
         rsp_pps_off_ff <= 8'(pps_off_in);
         rsp_pps_len_ff <= pps_len_final;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.is_key     = rsp_key_ff;
   assign rsp_chan.has_data   = rsp_data_ff;
   assign rsp_chan.has_sps    = rsp_sps_ff;
   assign rsp_chan.sps_offset = rsp_sps_off_ff;
   assign rsp_chan.sps_length = rsp_sps_len_ff;
   assign rsp_chan.has_pps    = rsp_pps_ff;
   assign rsp_chan.pps_offset = rsp_pps_off_ff;
   assign rsp_chan.pps_length = rsp_pps_len_ff;

endmodule

@@ verif/h264_nal_header_scanner_top_test.sv @@
// Self-checking testbench for the H.264 NAL header scanner: frames of bytes in, summaries out.
// Depends on nhs_pkg, the nhs_req_if/nhs_rsp_if interfaces and h264_nal_header_scanner_top.
`timescale 1ns / 1ps

module h264_nal_header_scanner_top_test;
   import nhs_pkg::*;

   localparam int SCAN_WINDOW  = NHS_WINDOW;
   localparam int BYTE_TARGET  = 1000;
   localparam int MIN_FRAMES   = 12;
   localparam int CALM_TAIL    = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 8;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic       is_key;
      logic       has_data;
      logic       has_sps;
      logic [7:0] sps_offset;
      logic [8:0] sps_length;
      logic       has_pps;
      logic [7:0] pps_offset;
      logic [8:0] pps_length;
   } summary_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   typedef enum logic [1:0] {REC_NONE, REC_SPS, REC_PPS} open_rec_type;

   logic clock;
   logic reset;

   nhs_req_if req_chan ();
   nhs_rsp_if rsp_chan ();

   h264_nal_header_scanner_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Bytes waiting to be offered, expected summaries, and the frame under construction.
   frame_byte_type byte_queue[$];
   summary_type    pending_summaries[$];
   logic [7:0]     frame_buf[$];

   int error_count    = 0;
   int summary_count  = 0;
   int bytes_accepted = 0;
   int total_bytes    = 0;
   int idle_cycles    = 0;
   bit byte_taken     = 1'b0;
   bit offering       = 1'b0;
   bit calm           = 1'b0;
   bit holding        = 1'b0;
   bit pressure_done  = 1'b0;
   int tx_gap         = 0;
   int rx_stall       = 0;
   int rx_hold_left   = 0;

   // Scanner state mirrored by the predictor.
   logic [7:0]   hist [HIST_DEPTH];
   logic [8:0]   seen;
   bit           saw_key, saw_data, saw_sps, saw_pps;
   logic [7:0]   sps_off, pps_off;
   logic [8:0]   sps_len, pps_len;
   open_rec_type open_rec;
   logic [2:0]   ckpts;
   bit           halted;

   function automatic void clear_scan();
      foreach (hist[k]) hist[k] = 8'h00;
      seen     = '0;
      saw_key  = 1'b0;
      saw_data = 1'b0;
      saw_sps  = 1'b0;
      saw_pps  = 1'b0;
      sps_off  = '0;
      pps_off  = '0;
      sps_len  = '0;
      pps_len  = '0;
      open_rec = REC_NONE;
      ckpts    = '0;
      halted   = 1'b0;
   endfunction

   // Sets the length of the open parameter-set record, ending at byte position at.
   function automatic void close_open(input logic [8:0] at);
      if (open_rec == REC_SPS) begin
         sps_len = (at >= sps_off) ? at - sps_off : 9'd0;
      end else if (open_rec == REC_PPS) begin
         pps_len = (at >= pps_off) ? at - pps_off : 9'd0;
      end
   endfunction

   function automatic void note_data();
      if (!saw_data) begin
         saw_data = 1'b1;
         ckpts++;
      end
   endfunction

   // Classifies the NAL header behind a start code found at position pos.
   function automatic void examine(input logic [8:0] pos);
      logic [4:0] ftype;
      bit         key;
      if (hist[0] != START_ZERO || hist[1] != START_ZERO || hist[2] != START_ONE) return;
      if (open_rec != REC_NONE) begin
         close_open(pos);
         open_rec = REC_NONE;
         ckpts++;
      end
      ftype = hist[3][4:0];
      key = (ftype == NAL_IDR) ||
            ((ftype == NAL_FU_A || ftype == NAL_FU_B) &&
             hist[4][4:0] == NAL_IDR && hist[4][7]);
      if (key) begin
         saw_key = 1'b1;
         ckpts++;
         note_data();
      end else if (ftype == NAL_SPS) begin
         saw_sps  = 1'b1;
         sps_off  = 8'(pos + HDR_OFFSET);
         open_rec = REC_SPS;
      end else if (ftype == NAL_PPS) begin
         saw_pps  = 1'b1;
         pps_off  = 8'(pos + HDR_OFFSET);
         open_rec = REC_PPS;
      end else if (ftype < NAL_DATA_LIMIT) begin
         note_data();
      end
   endfunction

   // Advances the scanner by one byte; returns 1 with the frame summary on the last byte.
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output summary_type s);
      logic [8:0] j;
      logic [8:0] span;
      j = seen;
      s = '0;
      if (j < SCAN_WINDOW && j >= HIST_DEPTH && !halted) begin
         examine(j - 9'(HIST_DEPTH));
         if (ckpts >= CHECKPOINT_LIMIT) halted = 1'b1;
      end
      for (int k = 0; k < HIST_DEPTH - 1; k++) hist[k] = hist[k + 1];
      hist[HIST_DEPTH - 1] = b;
      if (seen < SCAN_WINDOW) seen++;
      if (!last) return 1'b0;
      // A frame too short for any examined position reports an all-zero summary.
      if (j < HIST_DEPTH) clear_scan();
      span = (j < SCAN_WINDOW) ? j + 9'd1 : 9'(SCAN_WINDOW);
      close_open(span);
      s.is_key     = saw_key;
      s.has_data   = saw_data;
      s.has_sps    = saw_sps;
      s.sps_offset = sps_off;
      s.sps_length = sps_len;
      s.has_pps    = saw_pps;
      s.pps_offset = pps_off;
      s.pps_length = pps_len;
      clear_scan();
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("summary %0d: %s expected %0d, got %0d", summary_count, name, want, got);
      end
   endtask

   // Frame construction helpers.
   task automatic append_byte(input logic [7:0] b);
      frame_buf = {frame_buf, b};
   endtask

   task automatic add_nal(input logic [7:0] hdr, input logic [7:0] h1, input int body);
      append_byte(START_ZERO);
      append_byte(START_ZERO);
      append_byte(START_ONE);
      append_byte(hdr);
      append_byte(h1);
      repeat (body) append_byte(8'($urandom));
   endtask

   task automatic add_fill(input int n);
      repeat (n) append_byte(8'($urandom_range(1, 255)));
   endtask

   task automatic random_nal();
      logic [4:0] t;
      logic [7:0] h1;
      case ($urandom_range(0, 9))
         0:       t = NAL_IDR;
         1:       t = NAL_SPS;
         2:       t = NAL_PPS;
         3:       t = NAL_FU_A;
         4:       t = NAL_FU_B;
         5:       t = 5'd1;
         6:       t = 5'd6;
         default: t = 5'($urandom);
      endcase
      h1 = 8'($urandom);
      if ((t == NAL_FU_A || t == NAL_FU_B) && $urandom_range(0, 1) == 1) h1[4:0] = NAL_IDR;
      // Four-byte start codes now and then.
      if ($urandom_range(0, 4) == 0) append_byte(START_ZERO);
      add_nal({3'($urandom), t}, h1, $urandom_range(0, 10));
   endtask

   task automatic commit_frame();
      frame_byte_type fb;
      if (frame_buf.size() == 0) append_byte(8'($urandom));
      foreach (frame_buf[k]) begin
         fb.value = frame_buf[k];
         fb.last  = (k == frame_buf.size() - 1);
         byte_queue = {byte_queue, fb};
      end
      frame_buf.delete();
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: predicts on each byte transfer and checks each summary transfer.
   always @(posedge clock) begin
      summary_type want_s;
      summary_type got_s;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            byte_taken = 1'b1;
            bytes_accepted++;
            if (scan_byte(req_chan.byte_value, req_chan.last_byte, want_s))
               pending_summaries = {pending_summaries, want_s};
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_summaries.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("summary %0d: arrived with none expected", summary_count);
            end else begin
               want_s = pending_summaries.pop_front();
               got_s.is_key     = rsp_chan.is_key;
               got_s.has_data   = rsp_chan.has_data;
               got_s.has_sps    = rsp_chan.has_sps;
               got_s.sps_offset = rsp_chan.sps_offset;
               got_s.sps_length = rsp_chan.sps_length;
               got_s.has_pps    = rsp_chan.has_pps;
               got_s.pps_offset = rsp_chan.pps_offset;
               got_s.pps_length = rsp_chan.pps_length;
               check_field("is_key", 9'(want_s.is_key), 9'(got_s.is_key));
               check_field("has_data", 9'(want_s.has_data), 9'(got_s.has_data));
               check_field("has_sps", 9'(want_s.has_sps), 9'(got_s.has_sps));
               check_field("sps_offset", 9'(want_s.sps_offset), 9'(got_s.sps_offset));
               check_field("sps_length", want_s.sps_length, got_s.sps_length);
               check_field("has_pps", 9'(want_s.has_pps), 9'(got_s.has_pps));
               check_field("pps_offset", 9'(want_s.pps_offset), 9'(got_s.pps_offset));
               check_field("pps_length", want_s.pps_length, got_s.pps_length);
            end
            summary_count++;
         end
         calm    = (bytes_accepted >= total_bytes - CALM_TAIL);
         holding = (rx_hold_left > 0);
      end
   end

   // Driver: offers queued bytes, with random idle bursts except near the end.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (byte_taken) begin
            byte_queue.delete(0);
            byte_taken = 1'b0;
            offering   = 1'b0;
         end
         if (!offering) begin
            if (tx_gap > 0 && !holding) begin
               tx_gap--;
               req_chan.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               tx_gap = 0;
               req_chan.valid      <= 1'b1;
               req_chan.byte_value <= byte_queue[0].value;
               req_chan.last_byte  <= byte_queue[0].last;
               offering = 1'b1;
               if (!calm && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 11);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!pressure_done && summary_count >= HOLD_AFTER) begin
            rx_hold_left  = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 11);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("h264_nal_header_scanner_top_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int style;
      int target_len;
      int frames_made;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte  = 1'b0;
      rsp_chan.ready      = 1'b0;
      clear_scan();
      frames_made = 0;

      // A single all-ones byte that ends its frame at once.
      append_byte(8'hFF);
      commit_frame();
      // Five bytes: no position is ever examined, so the summary is all zeros.
      add_nal({3'b011, NAL_IDR}, 8'h88, 0);
      commit_frame();
      // Six bytes: the first position is examined on the last byte.
      add_nal({3'b011, NAL_IDR}, 8'h88, 1);
      commit_frame();
      // SPS and PPS closed by the next start code, then a plain slice.
      add_nal({3'b011, NAL_SPS}, 8'h42, 2);
      add_nal({3'b011, NAL_PPS}, 8'hCE, 1);
      add_nal({3'b010, 5'd1}, 8'h9A, 3);
      commit_frame();
      // FU-A fragment starting an IDR slice.
      add_nal({3'b011, NAL_FU_A}, {1'b1, 2'b00, NAL_IDR}, 2);
      commit_frame();
      // FU-B without its start bit, SEI and type zero: not key.
      add_nal({3'b011, NAL_FU_B}, {1'b0, 2'b00, NAL_IDR}, 1);
      add_nal({3'b000, 5'd6}, 8'h05, 1);
      add_nal({3'b111, 5'd0}, 8'h00, 2);
      commit_frame();
      // Four checkpoints stop scanning; the second SPS goes unseen.
      add_nal({3'b011, NAL_SPS}, 8'h42, 1);
      add_nal({3'b011, NAL_PPS}, 8'hCE, 1);
      add_nal({3'b011, NAL_IDR}, 8'h88, 1);
      add_nal({3'b011, NAL_SPS}, 8'h42, 6);
      commit_frame();
      // Frame longer than the window with an SPS still open at the window edge.
      add_fill(230);
      add_nal({3'b011, NAL_SPS}, 8'h42, 0);
      add_fill(70);
      commit_frame();

      // Random frames: mostly well-formed NAL sequences, some noise and broken ones.
      while (byte_queue.size() < BYTE_TARGET || frames_made < MIN_FRAMES) begin
         style = $urandom_range(0, 99);
         if (style < 3) begin
            target_len = $urandom_range(250, 320);
            while (frame_buf.size() < target_len) random_nal();
         end else if (style < 10) begin
            repeat ($urandom_range(1, 12))
               append_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
         end else if (style < 16) begin
            // Start code cut short, then maybe a proper unit.
            append_byte(START_ZERO);
            append_byte(START_ZERO);
            if ($urandom_range(0, 1) == 1) append_byte(START_ONE);
            if ($urandom_range(0, 1) == 1) random_nal();
         end else begin
            if ($urandom_range(0, 3) == 0) add_fill($urandom_range(1, 4));
            repeat ($urandom_range(1, 5)) random_nal();
         end
         commit_frame();
         frames_made++;
      end
      total_bytes = byte_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("h264_nal_header_scanner_top_test: PASS");
      end else begin
         $display("h264_nal_header_scanner_top_test: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/nhs_pkg.sv
hdl/nhs_intf.sv
hdl/nhs_front.sv
hdl/nhs_queue.sv
hdl/nhs_back.sv
hdl/h264_nal_header_scanner_top.sv
verif/h264_nal_header_scanner_top_test.sv
